### hdl/wheel_odometry_dead_reckoning_defines.svh
// Assertion macros for the odometry block.
// WODR_ASSERT_IMP: same-cycle implication, WODR_ASSERT_NXT: next-cycle implication.
`ifndef WHEEL_ODOMETRY_DEAD_RECKONING_DEFINES_SVH
`define WHEEL_ODOMETRY_DEAD_RECKONING_DEFINES_SVH

`ifndef SYNTH
`define WODR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odometry assertion failed (same cycle)");
`define WODR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odometry assertion failed (next cycle)");
`else
`define WODR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WODR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/wodr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wodr_pkg;

  localparam int DATA_W            = 32;
  localparam int ANG_W             = 34;
  localparam int MUL_W             = 33;
  localparam int PROD_W            = 2 * MUL_W;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int ATAN_IDX_W        = $clog2(ATAN_ENTRIES);
  localparam int ITER_W            = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_GAIN    = 34'sd652032874;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_METRES_PER_COUNT = 2'd0,
    CFG_SPEED_GAIN       = 2'd1,
    CFG_POSITION_STEP    = 2'd2
  } cfg_reg_t;

  localparam logic [23:0] MPC_RESET   = 24'd3088;
  localparam logic [15:0] GAIN_RESET  = 16'd200;
  localparam logic [15:0] PSTEP_RESET = 16'd66;

  typedef struct packed {
    logic busy;
    logic done;
  } cor_status_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] t;
    case (idx)
      5'd0:    t = 30'd843314856;
      5'd1:    t = 30'd497837829;
      5'd2:    t = 30'd263043836;
      5'd3:    t = 30'd133525158;
      5'd4:    t = 30'd67021686;
      5'd5:    t = 30'd33543515;
      5'd6:    t = 30'd16775850;
      5'd7:    t = 30'd8388437;
      5'd8:    t = 30'd4194282;
      5'd9:    t = 30'd2097149;
      5'd10:   t = 30'd1048575;
      5'd11:   t = 30'd524287;
      5'd12:   t = 30'd262143;
      5'd13:   t = 30'd131071;
      5'd14:   t = 30'd65535;
      5'd15:   t = 30'd32767;
      5'd16:   t = 30'd16383;
      5'd17:   t = 30'd8191;
      5'd18:   t = 30'd4095;
      5'd19:   t = 30'd2047;
      5'd20:   t = 30'd1023;
      5'd21:   t = 30'd511;
      5'd22:   t = 30'd255;
      5'd23:   t = 30'd127;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/wodr_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module wodr_mul (
  input  logic                               clk,
  input  logic signed [wodr_pkg::MUL_W-1:0]  op_a,
  input  logic signed [wodr_pkg::MUL_W-1:0]  op_b,
  output logic signed [wodr_pkg::PROD_W-1:0] prod_r
);
  import wodr_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

### hdl/wodr_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module wodr_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [15:0]                heading,
  output wodr_pkg::cor_status_t             status,
  output logic signed [wodr_pkg::DATA_W-1:0] cos_q30,
  output logic signed [wodr_pkg::DATA_W-1:0] sin_q30
);
  import wodr_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FIX
  } cstate_t;

  cstate_t                 state_r;
  logic [ITER_W-1:0]       iter_r;
  logic signed [ANG_W-1:0] x_r, y_r, a_r;
  logic signed [ANG_W-1:0] x_nxt, y_nxt, a_nxt;
  logic                    flip_r;
  logic                    done_r;
  logic signed [DATA_W-1:0] cos_r, sin_r;

  logic signed [ANG_W-1:0] a_in, a_fold;
  logic                    flip_in;
  logic [ATAN_IDX_W-1:0]   idx;
  logic signed [ANG_W-1:0] xs, ys, t_ang;
  logic signed [ANG_W-1:0] x_neg, y_neg;

  // heading Q3.13 to Q4.30, then fold by a half turn
  always_comb begin
    a_in    = {heading[15], heading, 17'b0};
    a_fold  = a_in;
    flip_in = 1'b0;
    if (a_in > Q30_HALF_PI) begin
      a_fold  = a_in - Q30_PI;
      flip_in = 1'b1;
    end else if (a_in < -Q30_HALF_PI) begin
      a_fold  = a_in + Q30_PI;
      flip_in = 1'b1;
    end
  end

  // one micro-rotation per cycle through the shifters shared by all iterations
  always_comb begin
    idx   = ATAN_IDX_W'(iter_r);
    xs    = x_r >>> idx;
    ys    = y_r >>> idx;
    t_ang = {{(ANG_W-30){1'b0}}, atan_q30(idx)};
    if (!a_r[ANG_W-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      a_nxt = a_r - t_ang;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      a_nxt = a_r + t_ang;
    end
    x_neg = -x_r;
    y_neg = -y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            state_r <= C_RUN;
            done_r  <= 1'b0;
          end
        end
        C_RUN: begin
          if (iter_r == ITER_W'(CORDIC_ITERATIONS - 1)) begin
            state_r <= C_FIX;
          end
        end
        C_FIX: begin
          state_r <= C_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && start) begin
      x_r    <= Q30_GAIN;
      y_r    <= '0;
      a_r    <= a_fold;
      flip_r <= flip_in;
      iter_r <= '0;
    end else if (state_r == C_RUN) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      iter_r <= iter_r + 1'b1;
    end
    if (state_r == C_FIX) begin
      cos_r <= flip_r ? x_neg[DATA_W-1:0] : x_r[DATA_W-1:0];
      sin_r <= flip_r ? y_neg[DATA_W-1:0] : y_r[DATA_W-1:0];
    end
  end

  assign status.busy = (state_r != C_IDLE);
  assign status.done = done_r;
  assign cos_q30     = cos_r;
  assign sin_q30     = sin_r;

endmodule

`default_nettype wire

### hdl/wheel_odometry_dead_reckoning.sv
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    in_count_delta, in_heading
// out      out  out_valid / out_stall  out_travelled, out_speed, out_pos_x_out, out_pos_y_out
// cfg      in   cfg_we                 cfg_addr, cfg_wdata
//
// The interval from one transfer in to the next possible transfer in is set by the
// iterative CORDIC; the input stalls until the item is done, and the scaling
// products run on the shared multiplier while it rotates.
// Synchronous active-low reset restores register defaults and clears the accumulators.
// A finished result waits in the output register; a new item is taken meanwhile and
// only holds in its last step while that register is still occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "wheel_odometry_dead_reckoning_defines.svh"

module wheel_odometry_dead_reckoning (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [15:0]                    in_count_delta,
  input  logic signed [15:0]                    in_heading,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wodr_pkg::DATA_W-1:0]    out_travelled,
  output logic signed [wodr_pkg::DATA_W-1:0]    out_speed,
  output logic signed [wodr_pkg::DATA_W-1:0]    out_pos_x_out,
  output logic signed [wodr_pkg::DATA_W-1:0]    out_pos_y_out,
  input  logic                                  cfg_we,
  input  logic [wodr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [wodr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import wodr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P,
    S_GLO,
    S_GHI,
    S_SPD,
    S_SAT,
    S_VDT,
    S_VRND,
    S_MX,
    S_MY,
    S_AX,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [23:0] mpc_r;
  logic [15:0] gain_r, pstep_r;

  logic [DATA_W-1:0] dist_r, posx_r, posy_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_trav_r, out_spd_r, out_x_r, out_y_r;

  logic signed [16:0] d_r;
  logic [40:0]        p_r;
  logic [40:0]        lo_r;
  logic [57:0]        pg_r;
  logic [DATA_W-1:0]  spd_r, vdt_r, rx_r, ry_r;

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;

  cor_status_t              cor_st;
  logic signed [DATA_W-1:0] cor_cos, cor_sin;

  logic in_acc, out_free;
  logic [40:0] p_rnd, lo_sum;
  logic [57:0] pg_sum;
  logic [49:0] spd_wide;
  logic        spd_fits;
  logic [DATA_W-1:0] spd_sat;
  logic [47:0] vdt_sum;
  logic [61:0] rnd30;
  logic [16:0] d_neg;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  wodr_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  wodr_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .heading (in_heading),
    .status  (cor_st),
    .cos_q30 (cor_cos),
    .sin_q30 (cor_sin)
  );

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_P: begin
        op_a = MUL_W'(d_r);
        op_b = {9'b0, mpc_r};
      end
      S_GLO: begin
        op_a = {9'b0, prod[23:0]};
        op_b = {17'b0, gain_r};
      end
      S_GHI: begin
        op_a = {{16{p_r[40]}}, p_r[40:24]};
        op_b = {17'b0, gain_r};
      end
      S_VDT: begin
        op_a = {spd_r[DATA_W-1], spd_r};
        op_b = {17'b0, pstep_r};
      end
      S_MX: begin
        op_a = {vdt_r[DATA_W-1], vdt_r};
        op_b = {cor_cos[DATA_W-1], cor_cos};
      end
      S_MY: begin
        op_a = {vdt_r[DATA_W-1], vdt_r};
        op_b = {cor_sin[DATA_W-1], cor_sin};
      end
      default: ;
    endcase
  end

  // rounding adds: add half an LSB, then drop the low bits; also negate the count and saturate the speed
  always_comb begin
    d_neg    = -{in_count_delta[15], in_count_delta};
    p_rnd    = p_r + 41'd128;
    lo_sum   = prod[40:0] + 41'd128;
    pg_sum   = {prod[33:0], 24'b0} + {17'b0, lo_r};
    spd_wide = pg_r[57:8];
    spd_fits = (spd_wide[49:31] == '0) || (spd_wide[49:31] == '1);
    if (spd_fits) begin
      spd_sat = spd_wide[DATA_W-1:0];
    end else if (spd_wide[49]) begin
      spd_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      spd_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
    vdt_sum  = prod[47:0] + 48'h8000;
    rnd30    = prod[61:0] + 62'h2000_0000;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_P;
      S_P:    state_nxt = S_GLO;
      S_GLO:  state_nxt = S_GHI;
      S_GHI:  state_nxt = S_SPD;
      S_SPD:  state_nxt = S_SAT;
      S_SAT:  state_nxt = S_VDT;
      S_VDT:  state_nxt = S_VRND;
      S_VRND: state_nxt = S_MX;
      S_MX:   if (cor_st.done) state_nxt = S_MY;
      S_MY:   state_nxt = S_AX;
      S_AX:   state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mpc_r       <= MPC_RESET;
      gain_r      <= GAIN_RESET;
      pstep_r     <= PSTEP_RESET;
      dist_r      <= '0;
      posx_r      <= '0;
      posy_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_METRES_PER_COUNT: mpc_r   <= cfg_wdata;
          CFG_SPEED_GAIN:       gain_r  <= cfg_wdata[15:0];
          CFG_POSITION_STEP:    pstep_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (state_r == S_GHI) begin
        dist_r <= dist_r + p_rnd[39:8];
      end
      if (state_r == S_AX) begin
        posx_r <= posx_r + rx_r;
      end
      if (state_r == S_DONE && out_free) begin
        posy_r      <= posy_r + ry_r;
        out_valid_r <= 1'b1;
        out_trav_r  <= dist_r;
        out_spd_r   <= spd_r;
        out_x_r     <= posx_r;
        out_y_r     <= posy_r + ry_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (in_acc) d_r <= d_neg;
    unique case (state_r)
      S_GLO:  p_r   <= prod[40:0];
      S_GHI:  lo_r  <= lo_sum;
      S_SPD:  pg_r  <= pg_sum;
      S_SAT:  spd_r <= spd_sat;
      S_VRND: vdt_r <= vdt_sum[47:16];
      S_MY:   rx_r  <= rnd30[61:30];
      S_AX:   ry_r  <= rnd30[61:30];
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_travelled = out_trav_r;
  assign out_speed     = out_spd_r;
  assign out_pos_x_out = out_x_r;
  assign out_pos_y_out = out_y_r;

  `WODR_ASSERT_NXT(a_accept_blocks_next, clk, rst_n, in_valid && !in_stall, in_stall)
  `WODR_ASSERT_IMP(a_cordic_ready_for_sin, clk, rst_n, state_r == S_MY, cor_st.done)
  `WODR_ASSERT_IMP(a_cordic_quiet_when_idle, clk, rst_n, state_r == S_IDLE, !cor_st.busy)

endmodule

`default_nettype wire

### tb/tb_wheel_odometry_dead_reckoning.sv
`timescale 1ns / 1ps

module tb_wheel_odometry_dead_reckoning;
  import wodr_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 163;
  localparam int NUM_PHASES = 10;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint SPD_MAX = 64'sd2147483647;
  localparam longint SPD_MIN = -64'sd2147483648;
  localparam int ATAN_LEN = 24;
  localparam longint ATAN_TABLE [ATAN_LEN] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  typedef struct {
    logic [31:0] travelled;
    logic [31:0] speed;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } odo_report_t;

  class odometry_tracker;
    longint mpc;
    longint gain;
    longint pstep;
    logic [31:0] trav_acc;
    logic [31:0] px;
    logic [31:0] py;
    odo_report_t pending_reports[$];
    int errors;

    function new();
      mpc = 3088;
      gain = 200;
      pstep = 66;
      trav_acc = '0;
      px = '0;
      py = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_METRES_PER_COUNT: mpc = longint'(val);
        CFG_SPEED_GAIN: gain = longint'(val[15:0]);
        CFG_POSITION_STEP: pstep = longint'(val[15:0]);
        default: ;
      endcase
    endfunction

    // round half up: floor((v + 2^(sh-1)) / 2^sh)
    function longint round_q(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // cos and sin of the heading in Q1.30; fold by a half turn outside +-pi/2
    function void heading_unit(logic signed [15:0] hdg, output longint cs,
                               output longint sn);
      longint ang;
      longint x;
      longint y;
      longint xs;
      longint ys;
      bit flip;
      ang = longint'(hdg) * 131072;
      x = GAIN_Q30;
      y = 0;
      flip = 1'b0;
      if (ang > HALF_PI_Q30) begin
        ang = ang - PI_Q30;
        flip = 1'b1;
      end else if (ang < -HALF_PI_Q30) begin
        ang = ang + PI_Q30;
        flip = 1'b1;
      end
      for (int i = 0; i < wodr_pkg::CORDIC_ITERATIONS && i < ATAN_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (ang >= 0) begin
          x = x - ys;
          y = y + xs;
          ang = ang - ATAN_TABLE[i];
        end else begin
          x = x + ys;
          y = y - xs;
          ang = ang + ATAN_TABLE[i];
        end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
    endfunction

    function void note_tick(logic signed [15:0] cnt, logic signed [15:0] hdg);
      longint prod;
      longint stp;
      longint spd;
      longint vdt;
      longint cs;
      longint sn;
      longint dx;
      longint dy;
      odo_report_t r;
      prod = -longint'(cnt) * mpc;
      stp = round_q(prod, 8);
      spd = round_q(prod * gain, 8);
      if (spd > SPD_MAX) spd = SPD_MAX;
      else if (spd < SPD_MIN) spd = SPD_MIN;
      trav_acc = trav_acc + stp[31:0];
      vdt = round_q(spd * pstep, 16);
      heading_unit(hdg, cs, sn);
      dx = round_q(vdt * cs, 30);
      dy = round_q(vdt * sn, 30);
      px = px + dx[31:0];
      py = py + dy[31:0];
      r.travelled = trav_acc;
      r.speed = spd[31:0];
      r.pos_x = px;
      r.pos_y = py;
      pending_reports.push_back(r);
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function void check_report(logic [31:0] trav, logic [31:0] spd, logic [31:0] x,
                               logic [31:0] y);
      odo_report_t r;
      if (pending_reports.size() == 0) begin
        $error("result transfer with no tick outstanding");
        errors++;
        return;
      end
      r = pending_reports.pop_front();
      cmp_field("travelled", r.travelled, trav);
      cmp_field("speed", r.speed, spd);
      cmp_field("pos_x_out", r.pos_x, x);
      cmp_field("pos_y_out", r.pos_y, y);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_count_delta = '0;
  logic signed [15:0] in_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_travelled;
  logic signed [DATA_W-1:0] out_speed;
  logic signed [DATA_W-1:0] out_pos_x_out;
  logic signed [DATA_W-1:0] out_pos_y_out;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_METRES_PER_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  odometry_tracker tracker = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic long_hold = 1'b0;
  event hold_ev;
  int quiet_cycles = 0;

  wheel_odometry_dead_reckoning dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_count_delta (in_count_delta),
    .in_heading     (in_heading),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_travelled  (out_travelled),
    .out_speed      (out_speed),
    .out_pos_x_out  (out_pos_x_out),
    .out_pos_y_out  (out_pos_y_out),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < receiver_stall_pct);
  end

  // hold the result channel off for a long stretch on request
  initial begin
    forever begin
      @(hold_ev);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_report(out_travelled, out_speed, out_pos_x_out, out_pos_y_out);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("** wheel_odometry_dead_reckoning: FAILED **");
    $finish;
  end

  task automatic send_tick(input logic signed [15:0] cnt, input logic signed [15:0] hdg);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_count_delta <= cnt;
    in_heading <= hdg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_tick(cnt, hdg);
  endtask

  task automatic drain_reports();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic program_odometry(input logic [CFG_DATA_W-1:0] mpc_w,
                                  input logic [CFG_DATA_W-1:0] gain_w,
                                  input logic [CFG_DATA_W-1:0] pstep_w);
    in_valid <= 1'b0;
    drain_reports();
    repeat (30) @(posedge clk);
    write_reg(CFG_METRES_PER_COUNT, mpc_w);
    write_reg(CFG_SPEED_GAIN, gain_w);
    write_reg(CFG_POSITION_STEP, pstep_w);
    write_reg(CFG_UNUSED, 24'($urandom()));
    cfg_we <= 1'b0;
  endtask

  task automatic random_tick();
    logic signed [15:0] cnt;
    logic signed [15:0] hdg;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) cnt = 16'($urandom_range(400) - 200);
    else if (pick < 85) cnt = 16'($urandom_range(8000) - 4000);
    else cnt = 16'($urandom());
    if ($urandom_range(99) < 80) hdg = 16'($urandom_range(51472) - 25736);
    else hdg = 16'($urandom());
    send_tick(cnt, hdg);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] mpc_w;
    logic [CFG_DATA_W-1:0] gain_w;
    logic [CFG_DATA_W-1:0] pstep_w;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: count extremes, quarter- and half-turn folds, out-of-range heading
    send_tick(16'sd0, 16'sd0);
    send_tick(-16'sd32768, 16'sd0);
    send_tick(16'sd32767, 16'sd0);
    send_tick(16'sd1, 16'sd12867);
    send_tick(-16'sd1, 16'sd12868);
    send_tick(-16'sd100, -16'sd12867);
    send_tick(16'sd100, -16'sd12868);
    send_tick(-16'sd1000, 16'sd25736);
    send_tick(16'sd1000, -16'sd25736);
    send_tick(-16'sd32768, 16'sd32767);
    send_tick(16'sd32767, -16'sd32768);
    send_tick(-16'sd5, 16'sd6434);
    send_tick(16'sd7, -16'sd19302);
    send_tick(-16'sd32768, 16'sd25736);

    // everything at full scale: speed saturates both ways, position wraps
    program_odometry(24'hFFFFFF, 24'h00FFFF, 24'h00FFFF);
    send_tick(-16'sd32768, 16'sd0);
    send_tick(16'sd32767, 16'sd12868);
    send_tick(-16'sd1, -16'sd12868);
    send_tick(16'sd1, 16'sd32767);
    send_tick(16'sd0, -16'sd32768);

    // zero gain and zero time step: distance moves, speed and position do not
    program_odometry(24'h123456, 24'h000000, 24'h000000);
    send_tick(-16'sd32768, 16'sd1000);
    send_tick(16'sd32767, -16'sd1000);
    send_tick(-16'sd300, 16'sd25000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin mpc_w = 24'd3088; gain_w = 24'd200; pstep_w = 24'd66; end
        2: begin mpc_w = 24'hFFFFFF; gain_w = 24'h00FFFF; pstep_w = 24'h00FFFF; end
        3: begin mpc_w = 24'd1; gain_w = 24'd1; pstep_w = 24'd1; end
        5: begin
          mpc_w = 24'd0; gain_w = 24'($urandom()); pstep_w = 24'($urandom());
        end
        7: begin mpc_w = 24'hFFFFFF; gain_w = 24'd1; pstep_w = 24'h00FFFF; end
        9: begin
          mpc_w = 24'($urandom_range(8000));
          gain_w = 24'($urandom());
          pstep_w = 24'($urandom());
        end
        default: begin
          mpc_w = 24'($urandom()); gain_w = 24'($urandom()); pstep_w = 24'($urandom());
        end
      endcase
      program_odometry(mpc_w, gain_w, pstep_w);
      case (ph % 4)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 74; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 74; end
        default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // back up the block with the sender still offering ticks
        if (ph == 4 && n == 30) -> hold_ev;
        // let the pipeline run dry mid-phase
        if (ph == 6 && n == 80) begin
          in_valid <= 1'b0;
          drain_reports();
        end
        random_tick();
      end
    end

    in_valid <= 1'b0;
    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("** wheel_odometry_dead_reckoning: PASSED **");
    else
      $display("** wheel_odometry_dead_reckoning: FAILED **");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/wodr_pkg.sv
hdl/wodr_mul.sv
hdl/wodr_cordic.sv
hdl/wheel_odometry_dead_reckoning.sv
tb/tb_wheel_odometry_dead_reckoning.sv
